FILE: hw/rtl/biss_pkg.sv
package biss_pkg;

	// Line sample and frame geometry
	localparam int SAMPLE_BITS     = 48;
	localparam int POS_BITS        = 17;
	localparam int ACK_BITS        = 13;
	localparam int CRC_BITS        = 6;
	localparam int DATA_BITS       = POS_BITS + 2;
	localparam int FRAME_BITS      = DATA_BITS + CRC_BITS;
	localparam int OVERHEAD_BITS   = ACK_BITS + 2;
	localparam int MAX_FRAME_START = SAMPLE_BITS - FRAME_BITS;
	localparam int MAX_ACK_START   = SAMPLE_BITS - OVERHEAD_BITS - FRAME_BITS;
	localparam int NUM_STARTS      = MAX_FRAME_START + 1;
	localparam int NUM_ACKS        = MAX_ACK_START + 1;
	localparam int START_BITS      = $clog2(NUM_STARTS + 1);
	localparam logic [START_BITS-1:0] NO_FRAME_CODE = START_BITS'(NUM_STARTS);

	// CRC6, x^6 + x + 1
	localparam logic [CRC_BITS-1:0] CRC_POLY = 6'h03;

	// Configuration registers
	localparam int TW_BITS        = 5;
	localparam int LIMIT_BITS     = 4;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = TW_BITS;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TRACK_WINDOW    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LOCK_FAIL_LIMIT = 2'd1;
	localparam logic [TW_BITS-1:0]      TRACK_WINDOW_RESET  = 5'd2;
	localparam logic [LIMIT_BITS-1:0]   FAIL_LIMIT_RESET    = 4'd3;

	// Result packing
	localparam int OUT_BITS       = 1 + POS_BITS + 1 + 1 + CRC_BITS + CRC_BITS + START_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;
	localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic [NUM_STARTS-1:0] crc_ok;  // frame at this start passes its CRC
		logic [NUM_ACKS-1:0]   ack_ok;  // acknowledge run and start bit at this offset
	} scan_t;

	typedef struct packed {
		logic [START_BITS-1:0] frame_start;
		logic [CRC_BITS-1:0]   crc_computed;
		logic [CRC_BITS-1:0]   crc_received;
		logic                  warning_flag;
		logic                  error_flag;
		logic [POS_BITS-1:0]   position;
		logic                  found;
	} result_t;

	// CRC contribution of a single one at data bit k (constant for a constant k).
	function automatic logic [CRC_BITS-1:0] crc6_column(input int k);
		logic [CRC_BITS-1:0] crc;
		logic                fb;
		crc = '0;
		for (int j = DATA_BITS - 1; j >= 0; j--) begin
			fb  = crc[CRC_BITS-1] ^ (j == k);
			crc = {crc[CRC_BITS-2:0], 1'b0};
			if (fb) crc = crc ^ CRC_POLY;
		end
		return crc;
	endfunction

	// The CRC is linear with a zero start value, so it is the XOR of the columns
	// of the set data bits.
	function automatic logic [CRC_BITS-1:0] crc6_of(input logic [DATA_BITS-1:0] data);
		logic [CRC_BITS-1:0] crc;
		crc = '0;
		for (int k = 0; k < DATA_BITS; k++) begin
			if (data[k]) crc = crc ^ crc6_column(k);
		end
		return crc;
	endfunction

endpackage

FILE: hw/rtl/biss_frame_align_decode.sv
// BiSS-C frame alignment and decoding.
// Input stream (s_axis_*): one 48-bit raw line sample per item, first received
// bit in the most significant position. Output stream (m_axis_*): one result
// item per input item, in order. Configuration channel (cfg_*): register 0 is
// the tracking half window, register 1 the lock failure limit; it is always
// ready and should only be written while no item is in flight.
// An accepted sample sits in an input register; from there all 24
// frame starts are CRC-checked in parallel, the tracking window or the
// acknowledge search picks one, the lock state is updated and the result is
// written to the output register once that register is free or being taken.
// One item per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the result waits in the output register while a
// further sample may be taken into the input register; further input is then
// held off until the result is taken.
// Reset clears the lock and the fail count, empties both item registers,
// and restores the configuration registers to a window of 2 and a limit of 3.
module biss_frame_align_decode (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [47:0] raw_sample
	input  logic [biss_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// [0] found, [17:1] position, [18] error_flag, [19] warning_flag,
	// [25:20] crc_received, [31:26] crc_computed, [36:32] frame_start, rest zero
	output logic [biss_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [biss_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [biss_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import biss_pkg::*;

	logic [TW_BITS-1:0]     track_window_q;
	logic [LIMIT_BITS-1:0]  fail_limit_q;
	logic                   lock_valid_q;
	logic [START_BITS-1:0]  locked_offset_q;
	logic [LIMIT_BITS-1:0]  fail_count_q;

	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] raw_s1;
	logic                   out_valid_q;
	result_t                result_q;

	logic                   advance;
	scan_t                  scan;
	logic [NUM_STARTS-1:0]  track_hit;
	logic [NUM_ACKS-1:0]    full_hit;
	logic                   track_any;
	logic                   full_any;
	logic [START_BITS-1:0]  track_sel;
	logic [START_BITS-1:0]  full_sel;
	logic                   found;
	logic [START_BITS-1:0]  sel;
	logic [SAMPLE_BITS-1:0] shifted;
	logic [FRAME_BITS-1:0]  sel_frame;
	result_t                result_d;
	logic                   lock_valid_d;
	logic [START_BITS-1:0]  locked_offset_d;
	logic [LIMIT_BITS-1:0]  fail_count_d;
	logic [LIMIT_BITS-1:0]  fail_inc;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_BITS-OUT_BITS){1'b0}}, result_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_window_q <= TRACK_WINDOW_RESET;
			fail_limit_q   <= FAIL_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TRACK_WINDOW:    track_window_q <= cfg_data[TW_BITS-1:0];
				CFG_LOCK_FAIL_LIMIT: fail_limit_q   <= cfg_data[LIMIT_BITS-1:0];
				default: ;
			endcase
		end
	end

	biss_scan u_scan (
		.raw  (raw_s1),
		.scan (scan)
	);

	// Tracking window around the locked start; the candidate range itself
	// provides the clamp to valid starts.
	for (genvar s = 0; s < NUM_STARTS; s++) begin : g_win
		logic [START_BITS:0] lo_sum;
		logic [START_BITS:0] hi_sum;
		assign lo_sum = (START_BITS+1)'(s) + (START_BITS+1)'(track_window_q);
		assign hi_sum = (START_BITS+1)'(locked_offset_q) + (START_BITS+1)'(track_window_q);
		assign track_hit[s] = scan.crc_ok[s] &&
			(lo_sum >= (START_BITS+1)'(locked_offset_q)) &&
			((START_BITS+1)'(s) <= hi_sum);
	end

	for (genvar a = 0; a < NUM_ACKS; a++) begin : g_full
		assign full_hit[a] = scan.ack_ok[a] && scan.crc_ok[a + OVERHEAD_BITS];
	end

	assign track_any = lock_valid_q && (track_hit != '0);
	assign full_any  = full_hit != '0;

	// Lowest passing start wins in both searches.
	always_comb begin
		track_sel = '0;
		for (int i = NUM_STARTS - 1; i >= 0; i--) begin
			if (track_hit[i]) track_sel = START_BITS'(i);
		end
		full_sel = '0;
		for (int i = NUM_ACKS - 1; i >= 0; i--) begin
			if (full_hit[i]) full_sel = START_BITS'(i + OVERHEAD_BITS);
		end
	end

	assign found     = track_any || full_any;
	assign sel       = track_any ? track_sel : full_sel;
	assign shifted   = raw_s1 << sel;
	assign sel_frame = shifted[SAMPLE_BITS-1 -: FRAME_BITS];
	assign fail_inc  = fail_count_q + LIMIT_BITS'(1);

	always_comb begin
		result_d = '0;
		result_d.frame_start = NO_FRAME_CODE;
		if (found) begin
			result_d.found        = 1'b1;
			result_d.position     = sel_frame[FRAME_BITS-1 -: POS_BITS];
			result_d.error_flag   = sel_frame[CRC_BITS+1];
			result_d.warning_flag = sel_frame[CRC_BITS];
			result_d.crc_received = sel_frame[CRC_BITS-1:0];
			result_d.crc_computed = crc6_of(sel_frame[FRAME_BITS-1:CRC_BITS]);
			result_d.frame_start  = sel;
		end
	end

	always_comb begin
		lock_valid_d    = lock_valid_q;
		locked_offset_d = locked_offset_q;
		fail_count_d    = fail_count_q;
		priority if (track_any) begin
			locked_offset_d = track_sel;
			fail_count_d    = '0;
		end else begin
			if (lock_valid_q) begin
				fail_count_d = fail_inc;
				if (fail_inc >= fail_limit_q) begin
					lock_valid_d    = 1'b0;
					locked_offset_d = '0;
					fail_count_d    = '0;
				end
			end
			// A full-search hit leaves the fail count as it stands.
			if (full_any) begin
				lock_valid_d    = 1'b1;
				locked_offset_d = full_sel;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			out_valid_q     <= 1'b0;
			lock_valid_q    <= 1'b0;
			locked_offset_q <= '0;
			fail_count_q    <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q     <= 1'b1;
				lock_valid_q    <= lock_valid_d;
				locked_offset_q <= locked_offset_d;
				fail_count_q    <= fail_count_d;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) raw_s1 <= s_axis_tdata[SAMPLE_BITS-1:0];
		if (advance) result_q <= result_d;
	end

	// Without a lock there is neither a remembered start nor a failure count.
	a_unlocked_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!lock_valid_q |-> (locked_offset_q == '0) && (fail_count_q == '0))
		else $error("offset or fail count kept without a lock");

	// The count is cleared before it can pass the largest limit.
	a_fail_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fail_count_q != '1)
		else $error("fail count reached its maximum");

	a_found_crc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.found |->
			(result_q.crc_received == ~result_q.crc_computed) &&
			(result_q.frame_start != NO_FRAME_CODE))
		else $error("found result with inconsistent CRC or start");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_q.found |->
			(result_q.frame_start == NO_FRAME_CODE) && (result_q.position == '0))
		else $error("empty result carries frame data");

	// While the output register is held, a sample waiting in the input register may not be lost.
	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(raw_s1))
		else $error("stalled sample lost");

endmodule

FILE: hw/rtl/biss_scan.sv
module biss_scan (
	input  logic [biss_pkg::SAMPLE_BITS-1:0] raw,
	output biss_pkg::scan_t                  scan
);
	import biss_pkg::*;

	// Every frame start is checked in parallel.
	for (genvar s = 0; s < NUM_STARTS; s++) begin : g_start
		logic [FRAME_BITS-1:0] frame;
		assign frame = raw[SAMPLE_BITS-1-s -: FRAME_BITS];
		assign scan.crc_ok[s] = frame[CRC_BITS-1:0] ==
			~crc6_of(frame[FRAME_BITS-1:CRC_BITS]);
	end

	for (genvar a = 0; a < NUM_ACKS; a++) begin : g_ack
		assign scan.ack_ok[a] = (raw[SAMPLE_BITS-1-a -: ACK_BITS] == '0) &&
			raw[SAMPLE_BITS-1-a-ACK_BITS];
	end

endmodule

FILE: tb/biss_decode_checker.sv
`timescale 1ns / 100ps

module biss_decode_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [biss_pkg::IN_TDATA_BITS-1:0]  s_tdata,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [biss_pkg::OUT_TDATA_BITS-1:0] m_tdata,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [biss_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [biss_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output int                                  mismatches,
	output int                                  outstanding
);
	import biss_pkg::*;

	logic [TW_BITS-1:0]    window_q;
	logic [LIMIT_BITS-1:0] limit_q;
	logic                  locked;
	logic [START_BITS-1:0] lock_start;
	logic [LIMIT_BITS-1:0] misses;
	result_t               expected_decodes[$];

	function automatic logic [CRC_BITS-1:0] crc6_msb_first(input logic [DATA_BITS-1:0] data);
		logic [CRC_BITS-1:0] crc;
		logic                fb;
		crc = '0;
		for (int k = DATA_BITS - 1; k >= 0; k--) begin
			fb  = crc[CRC_BITS-1] ^ data[k];
			crc = {crc[CRC_BITS-2:0], 1'b0};
			if (fb) crc = crc ^ CRC_POLY;
		end
		return crc;
	endfunction

	// Checks the frame at one start and fills in the decoded fields if its CRC holds.
	function automatic logic frame_ok(input logic [SAMPLE_BITS-1:0] raw, input int start,
			output result_t r);
		logic [FRAME_BITS-1:0] frame;
		logic [DATA_BITS-1:0]  data;
		logic [CRC_BITS-1:0]   calc;
		frame = raw[SAMPLE_BITS-1-start -: FRAME_BITS];
		data  = frame[FRAME_BITS-1:CRC_BITS];
		calc  = crc6_msb_first(data);
		r     = '0;
		if (frame[CRC_BITS-1:0] != CRC_BITS'(~calc)) return 1'b0;
		r.found        = 1'b1;
		r.position     = data[DATA_BITS-1:2];
		r.error_flag   = data[1];
		r.warning_flag = data[0];
		r.crc_received = frame[CRC_BITS-1:0];
		r.crc_computed = calc;
		r.frame_start  = START_BITS'(start);
		return 1'b1;
	endfunction

	// Tracking window first when locked, then the acknowledge search.
	function automatic result_t decode_sample(input logic [SAMPLE_BITS-1:0] raw);
		result_t r;
		int      lo;
		int      hi;
		if (locked) begin
			lo = int'(lock_start) - int'(window_q);
			hi = int'(lock_start) + int'(window_q);
			if (lo < 0) lo = 0;
			if (hi > MAX_FRAME_START) hi = MAX_FRAME_START;
			for (int s = lo; s <= hi; s++) begin
				if (frame_ok(raw, s, r)) begin
					lock_start = START_BITS'(s);
					misses     = '0;
					return r;
				end
			end
			misses = misses + 1'b1;
			if (misses >= limit_q) begin
				locked     = 1'b0;
				lock_start = '0;
				misses     = '0;
			end
		end
		for (int a = 0; a <= MAX_ACK_START; a++) begin
			if (raw[SAMPLE_BITS-1-a -: ACK_BITS] == '0 && raw[SAMPLE_BITS-1-a-ACK_BITS]
					&& frame_ok(raw, a + OVERHEAD_BITS, r)) begin
				// A find by search leaves the miss count where it was.
				locked     = 1'b1;
				lock_start = START_BITS'(a + OVERHEAD_BITS);
				return r;
			end
		end
		r = '0;
		r.frame_start = NO_FRAME_CODE;
		return r;
	endfunction

	function automatic int field_diff(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got === want) return 0;
		$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			window_q   = TRACK_WINDOW_RESET;
			limit_q    = FAIL_LIMIT_RESET;
			locked     = 1'b0;
			lock_start = '0;
			misses     = '0;
			expected_decodes.delete();
			outstanding = 0;
		end else begin
			// Results are matched before new samples are queued, so an item taken in
			// this cycle can never pair with a result leaving in the same cycle.
			if (m_tvalid && m_tready) begin
				if (expected_decodes.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing expected, expected none got %h",
						$time, m_tdata);
				end else begin
					want = expected_decodes.pop_front();
					got  = result_t'(m_tdata[OUT_BITS-1:0]);
					mismatches += field_diff("found", 32'(want.found), 32'(got.found));
					mismatches += field_diff("position", 32'(want.position), 32'(got.position));
					mismatches += field_diff("error_flag", 32'(want.error_flag),
						32'(got.error_flag));
					mismatches += field_diff("warning_flag", 32'(want.warning_flag),
						32'(got.warning_flag));
					mismatches += field_diff("crc_received", 32'(want.crc_received),
						32'(got.crc_received));
					mismatches += field_diff("crc_computed", 32'(want.crc_computed),
						32'(got.crc_computed));
					mismatches += field_diff("frame_start", 32'(want.frame_start),
						32'(got.frame_start));
					mismatches += field_diff("padding", 32'(0), 32'(m_tdata >> OUT_BITS));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TRACK_WINDOW:    window_q = cfg_data[TW_BITS-1:0];
					CFG_LOCK_FAIL_LIMIT: limit_q  = cfg_data[LIMIT_BITS-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_decodes.push_back(decode_sample(s_tdata[SAMPLE_BITS-1:0]));
			outstanding = expected_decodes.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import biss_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 183;
	localparam int TW_TABLE[6]     = '{0, 31, 23, 1, 5, 2};
	localparam int LIMIT_TABLE[6]  = '{1, 15, 0, 15, 2, 3};
	localparam int PCT_CHOICES[4]  = '{0, 10, 30, 60};

	typedef enum int {
		SMP_FRAME,
		SMP_TRACK,
		SMP_BAD_CRC,
		SMP_BAD_ACK,
		SMP_NOISE,
		SMP_FLAT
	} sample_kind_e;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_axis_tvalid = 1'b0;
	logic                       s_axis_tready;
	logic [IN_TDATA_BITS-1:0]   s_axis_tdata = '0;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0]  m_axis_tdata;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]   cfg_data = '0;

	int mismatches;
	int outstanding;
	int send_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int track_span = 2;
	int last_start = 0;

	biss_frame_align_decode dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	biss_decode_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_axis_tvalid),
		.s_tready    (s_axis_tready),
		.s_tdata     (s_axis_tdata),
		.m_tvalid    (m_axis_tvalid),
		.m_tready    (m_axis_tready),
		.m_tdata     (m_axis_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int pick_gap();
		return ($urandom_range(9) == 0) ? int'($urandom_range(40, 8)) : int'($urandom_range(3, 1));
	endfunction

	// The receiver stalls in bursts; a stall percentage of zero starts no new burst.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
			hold_left     <= pick_gap() - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	function automatic logic [CRC_BITS-1:0] frame_crc(input logic [DATA_BITS-1:0] data);
		logic [CRC_BITS-1:0] crc;
		logic                fb;
		crc = '0;
		for (int k = DATA_BITS - 1; k >= 0; k--) begin
			fb  = crc[CRC_BITS-1] ^ data[k];
			crc = {crc[CRC_BITS-2:0], 1'b0};
			if (fb) crc = crc ^ CRC_POLY;
		end
		return crc;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] rand_line();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [DATA_BITS-1:0] rand_data();
		logic [POS_BITS-1:0] pos;
		case ($urandom_range(7))
			0:       pos = '0;
			1:       pos = '1;
			default: pos = POS_BITS'($urandom);
		endcase
		return {pos, 2'($urandom)};
	endfunction

	// Writes a frame at the given start; a spoilt one has a single CRC bit flipped.
	function automatic logic [SAMPLE_BITS-1:0] place_frame(input logic [SAMPLE_BITS-1:0] raw,
			input int start, input logic [DATA_BITS-1:0] data, input logic spoil);
		logic [CRC_BITS-1:0] chk;
		chk = ~frame_crc(data);
		if (spoil) chk[$urandom_range(CRC_BITS-1)] ^= 1'b1;
		raw[SAMPLE_BITS-1-start -: FRAME_BITS] = {data, chk};
		return raw;
	endfunction

	// Acknowledge run and start bit at offset a, random CDS bit, frame after it.
	function automatic logic [SAMPLE_BITS-1:0] framed(input int a,
			input logic [DATA_BITS-1:0] data, input logic spoil);
		logic [SAMPLE_BITS-1:0] raw;
		raw = rand_line();
		raw[SAMPLE_BITS-1-a -: ACK_BITS+1] = {{ACK_BITS{1'b0}}, 1'b1};
		return place_frame(raw, a + OVERHEAD_BITS, data, spoil);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] make_sample(input sample_kind_e kind);
		logic [SAMPLE_BITS-1:0] raw;
		int                     a;
		int                     s;
		int                     reach;
		raw = rand_line();
		a   = $urandom_range(MAX_ACK_START);
		case (kind)
			SMP_FRAME: begin
				raw        = framed(a, rand_data(), 1'b0);
				last_start = a + OVERHEAD_BITS;
			end
			SMP_BAD_CRC: raw = framed(a, rand_data(), 1'b1);
			SMP_BAD_ACK: begin
				raw = framed(a, rand_data(), 1'b0);
				// Either one acknowledge bit goes high or the start bit goes low.
				raw[SAMPLE_BITS-1-a-int'($urandom_range(ACK_BITS))] ^= 1'b1;
			end
			SMP_TRACK: begin
				reach = track_span + 1;
				s     = last_start + int'($urandom_range(2 * reach)) - reach;
				if (s < 0) s = 0;
				if (s > MAX_FRAME_START) s = MAX_FRAME_START;
				raw        = place_frame(raw, s, rand_data(), 1'b0);
				last_start = s;
			end
			SMP_FLAT: raw = $urandom_range(1) ? '1 : '0;
			default: ;
		endcase
		return raw;
	endfunction

	function automatic sample_kind_e pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 40) return SMP_FRAME;
		if (r < 65) return SMP_TRACK;
		if (r < 75) return SMP_BAD_CRC;
		if (r < 83) return SMP_BAD_ACK;
		if (r < 95) return SMP_NOISE;
		return SMP_FLAT;
	endfunction

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] raw);
		int gap;
		gap = (send_pct != 0 && $urandom_range(99) < send_pct) ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= raw;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Successive writes keep valid high; the caller lowers it after the last one.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Outstanding is read at the falling edge, once the checker has settled.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int tw;
		int lim;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset settings: window 2, limit 3.
		send_sample('0);
		send_sample('1);
		send_sample(framed(0, '0, 1'b0));
		// Walk the lock down to start 0 by tracking alone.
		for (int s = OVERHEAD_BITS - 2; s >= -1; s -= 2)
			send_sample(place_frame(rand_line(), (s < 0) ? 0 : s, '1, 1'b0));
		send_sample(place_frame(rand_line(), 2, {17'h15555, 2'b10}, 1'b1));
		send_sample(rand_line());
		send_sample(rand_line());
		send_sample(framed(MAX_ACK_START, '1, 1'b0));
		send_sample(place_frame(rand_line(), MAX_FRAME_START, {17'h0AAAA, 2'b01}, 1'b0));
		send_sample(framed(MAX_ACK_START, rand_data(), 1'b1));
		// Found by search after a tracking miss, so the miss count is kept.
		send_sample(framed(4, rand_data(), 1'b0));
		send_sample(rand_line());
		send_sample(rand_line());
		drain();

		for (int p = 0; p < PHASES; p++) begin
			if (p < 6) begin
				tw  = TW_TABLE[p];
				lim = LIMIT_TABLE[p];
			end else begin
				tw  = $urandom_range(31);
				lim = $urandom_range(15);
			end
			write_reg(CFG_TRACK_WINDOW, TW_BITS'(tw));
			write_reg(CFG_LOCK_FAIL_LIMIT, {1'($urandom), LIMIT_BITS'(lim)});
			write_reg((p % 2 == 0) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_BITS'($urandom));
			cfg_valid  <= 1'b0;
			track_span = tw;
			send_pct   = (p == 0) ? 0 : PCT_CHOICES[$urandom_range(3)];
			stall_pct  = (p == 0) ? 0 : PCT_CHOICES[$urandom_range(3)];
			repeat (ITEMS_PER_PHASE) send_sample(make_sample(pick_kind()));
			drain();
		end

		if (mismatches == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
